FILE: rtl/core/schit_pkg.sv
`default_nettype none
package schit_pkg;

    // Sideband carried next to each pipeline stage
    typedef struct packed {
        logic valid;
    } schit_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/schit_diff.sv
`default_nettype none
module schit_diff
    import schit_pkg::*;
#(
    parameter int CB = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [CB-1:0] ax,
    input  wire logic signed [CB-1:0] ay,
    input  wire logic signed [CB-1:0] bx,
    input  wire logic signed [CB-1:0] by,
    input  wire logic signed [CB-1:0] cx,
    input  wire logic signed [CB-1:0] cy,
    input  wire logic        [CB-2:0] r,
    output logic signed [CB:0]        dx_reg,
    output logic signed [CB:0]        dy_reg,
    output logic signed [CB:0]        fx_reg,
    output logic signed [CB:0]        fy_reg,
    output logic signed [CB:0]        gx_reg,
    output logic signed [CB:0]        gy_reg,
    output logic        [CB-2:0]      r_reg
);

    // Form edge and offset vectors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= {bx[CB-1], bx} - {ax[CB-1], ax};
            dy_reg <= {by[CB-1], by} - {ay[CB-1], ay};
            fx_reg <= {ax[CB-1], ax} - {cx[CB-1], cx};
            fy_reg <= {ay[CB-1], ay} - {cy[CB-1], cy};
            gx_reg <= {bx[CB-1], bx} - {cx[CB-1], cx};
            gy_reg <= {by[CB-1], by} - {cy[CB-1], cy};
            r_reg  <= r;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/schit_quad.sv
`default_nettype none
module schit_quad
    import schit_pkg::*;
#(
    parameter int CB = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [CB:0]    dx,
    input  wire logic signed [CB:0]    dy,
    input  wire logic signed [CB:0]    fx,
    input  wire logic signed [CB:0]    fy,
    input  wire logic signed [CB:0]    gx,
    input  wire logic signed [CB:0]    gy,
    input  wire logic        [CB-2:0]  r,
    output logic signed [2*CB+3:0]     a_reg,
    output logic signed [2*CB+3:0]     h_reg,
    output logic signed [2*CB+3:0]     q0_reg,
    output logic signed [2*CB+3:0]     q1_reg
);

    localparam int W = 2 * CB + 4;

    logic signed [2*CB+1:0] pdx, pdy, pfx, pfy, pgx, pgy, phx, phy;
    logic signed [2*CB+1:0] pr;
    logic signed [2*CB+1:0] dx2_reg, dy2_reg, fx2_reg, fy2_reg;
    logic signed [2*CB+1:0] gx2_reg, gy2_reg, hx_reg, hy_reg, r2_reg;

    assign pdx = dx * dx;
    assign pdy = dy * dy;
    assign pfx = fx * fx;
    assign pfy = fy * fy;
    assign pgx = gx * gx;
    assign pgy = gy * gy;
    assign phx = fx * dx;
    assign phy = fy * dy;
    assign pr  = $signed({{(CB+3){1'b0}}, r}) * $signed({{(CB+3){1'b0}}, r});

    // Register the products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx2_reg <= pdx;
            dy2_reg <= pdy;
            fx2_reg <= pfx;
            fy2_reg <= pfy;
            gx2_reg <= pgx;
            gy2_reg <= pgy;
            hx_reg  <= phx;
            hy_reg  <= phy;
            r2_reg  <= pr;
        end
    end

    // Sum into the quadratic's coefficients
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= W'(dx2_reg) + W'(dy2_reg);
            h_reg  <= W'(hx_reg) + W'(hy_reg);
            q0_reg <= W'(fx2_reg) + W'(fy2_reg) - W'(r2_reg);
            q1_reg <= W'(gx2_reg) + W'(gy2_reg) - W'(r2_reg);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/schit_decide.sv
`default_nettype none
module schit_decide
    import schit_pkg::*;
#(
    parameter int CB = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [2*CB+3:0] a,
    input  wire logic signed [2*CB+3:0] h,
    input  wire logic signed [2*CB+3:0] q0,
    input  wire logic signed [2*CB+3:0] q1,
    output logic                       hit_reg
);

    localparam int W  = 2 * CB + 4;
    localparam int HL = W / 2;

    logic [W-1:0]   nh, ua, uq;
    logic           pre_hit, need_disc;
    logic [HL-1:0]  nh_lo, nh_hi, a_lo, a_hi, q_lo, q_hi;
    logic [2*HL-1:0] hll_reg, hlh_reg, hhh_reg, all_reg, alh_reg, ahl_reg, ahh_reg;
    logic           pre_reg, need_reg;
    logic [4*HL+1:0] lhs, rhs;

    assign nh = W'(-h);
    assign ua = W'(a);
    assign uq = W'(q0);
    assign nh_lo = nh[HL-1:0];
    assign nh_hi = HL'(nh[W-1:HL]);
    assign a_lo  = ua[HL-1:0];
    assign a_hi  = HL'(ua[W-1:HL]);
    assign q_lo  = uq[HL-1:0];
    assign q_hi  = HL'(uq[W-1:HL]);

    // Classify by end-point signs
    always_comb
    begin
        pre_hit   = 1'b0;
        need_disc = 1'b0;
        if (a != '0)
        begin
            if ((q0 <= 0 && q1 >= 0) || (q0 >= 0 && q1 <= 0))
                pre_hit = 1'b1;
            else if (q0 > 0 && q1 > 0 && h < 0 && -h < a)
                need_disc = 1'b1;
        end
    end

    // Register partial products of h*h and a*q0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hll_reg  <= nh_lo * nh_lo;
            hlh_reg  <= nh_lo * nh_hi;
            hhh_reg  <= nh_hi * nh_hi;
            all_reg  <= a_lo * q_lo;
            alh_reg  <= a_lo * q_hi;
            ahl_reg  <= a_hi * q_lo;
            ahh_reg  <= a_hi * q_hi;
            pre_reg  <= pre_hit;
            need_reg <= need_disc;
        end
    end

    assign lhs = {2'b0, hhh_reg, {(2*HL){1'b0}}}
               + ({(HL+2)'(0), hlh_reg, {HL{1'b0}}} << 1)
               + (4*HL+2)'(hll_reg);
    assign rhs = {2'b0, ahh_reg, {(2*HL){1'b0}}}
               + {(HL+2)'(0), alh_reg, {HL{1'b0}}}
               + {(HL+2)'(0), ahl_reg, {HL{1'b0}}}
               + (4*HL+2)'(all_reg);

    // Compare discriminant and combine
    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= pre_reg | (need_reg & (lhs >= rhs));
    end

endmodule
`default_nettype wire

FILE: rtl/core/segment_circle_hit_test.sv
`default_nettype none
// Result: the result of each input transaction is held in the last stage.
// Throughput: one transaction per cycle; the five-stage arithmetic pipe stalls as a whole.
// Stages: differences, squares, sums, sign test with split products, compare.
// Reset: rst_n asynchronously clears all stage valid bits; data registers are not reset.
module segment_circle_hit_test
    import schit_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, circle_x, circle_y, circle_radius
    input  wire logic [((7*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // hit
    output logic [7:0]                      m_axis_tdata
);

    localparam int CB = COORD_BITS;
    localparam int NS = 5;

    schit_ctl_t [NS-1:0] vld_reg;
    logic en;
    logic signed [CB:0] dx, dy, fx, fy, gx, gy;
    logic [CB-2:0] r1;
    logic signed [2*CB+3:0] a, h, q0, q1;
    logic hit;

    // Advance whenever the last stage is empty or drains
    assign en = !vld_reg[NS-1].valid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NS-1].valid;
    assign m_axis_tdata  = {7'b0, hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
    end

    schit_diff #(.CB(CB)) u_diff (
        .clk(clk), .en(en),
        .ax(s_axis_tdata[CB-1:0]),      .ay(s_axis_tdata[2*CB-1:CB]),
        .bx(s_axis_tdata[3*CB-1:2*CB]), .by(s_axis_tdata[4*CB-1:3*CB]),
        .cx(s_axis_tdata[5*CB-1:4*CB]), .cy(s_axis_tdata[6*CB-1:5*CB]),
        .r(s_axis_tdata[7*CB-2:6*CB]),
        .dx_reg(dx), .dy_reg(dy), .fx_reg(fx), .fy_reg(fy),
        .gx_reg(gx), .gy_reg(gy), .r_reg(r1)
    );

    schit_quad #(.CB(CB)) u_quad (
        .clk(clk), .en(en), .dx(dx), .dy(dy), .fx(fx), .fy(fy),
        .gx(gx), .gy(gy), .r(r1),
        .a_reg(a), .h_reg(h), .q0_reg(q0), .q1_reg(q1)
    );

    schit_decide #(.CB(CB)) u_decide (
        .clk(clk), .en(en), .a(a), .h(h), .q0(q0), .q1(q1), .hit_reg(hit)
    );

    // Stalled output holds its valid
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    // Accepted transaction reaches the output stage when the pipeline never stalls on its way
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready ##1 en ##1 en ##1 en ##1 en |=> m_axis_tvalid)
        else $error("transaction lost in pipeline");

    // Pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
        else $error("output padding not zero");

endmodule
`default_nettype wire

FILE: sim/hit_checker.sv
module hit_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [111:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [7:0]   m_axis_tdata,
    output int                errors,
    output int                pending
);

    logic [7:0] expected_hits[$];

    // Exact integer decision for one segment against one circle
    function automatic logic predict_hit(logic [111:0] d);
        logic signed [16:0] dx, dy, fx, fy, gx, gy;
        logic signed [63:0] a, h, r2, q0, q1;
        logic [127:0] lhs, rhs;
        dx = $signed(d[47:32]) - $signed(d[15:0]);
        dy = $signed(d[63:48]) - $signed(d[31:16]);
        fx = $signed(d[15:0]) - $signed(d[79:64]);
        fy = $signed(d[31:16]) - $signed(d[95:80]);
        gx = $signed(d[47:32]) - $signed(d[79:64]);
        gy = $signed(d[63:48]) - $signed(d[95:80]);
        a = 64'(dx) * dx + 64'(dy) * dy;
        h = 64'(fx) * dx + 64'(fy) * dy;
        r2 = $signed({49'd0, d[110:96]}) * $signed({49'd0, d[110:96]});
        q0 = 64'(fx) * fx + 64'(fy) * fy - r2;
        q1 = 64'(gx) * gx + 64'(gy) * gy - r2;
        if (a == 0)
            return 1'b0;
        if ((q0 <= 0 && q1 >= 0) || (q0 >= 0 && q1 <= 0))
            return 1'b1;
        if (q0 < 0 && q1 < 0)
            return 1'b0;
        if (!(h < 0 && -h < a))
            return 1'b0;
        lhs = 128'(-h) * 128'(-h);
        rhs = 128'(a) * 128'(q0);
        return lhs >= rhs;
    endfunction

    assign pending = expected_hits.size();

    // Predict on input transaction, compare on output transaction
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_hits.push_back({7'd0, predict_hit(s_axis_tdata)});
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: hit=%0d", m_axis_tdata);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (want !== m_axis_tdata)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("hit mismatch: expected %0d actual %0d", want, m_axis_tdata);
                end
            end
        end
    end

endmodule

FILE: sim/tb.sv
module tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    int           errors;
    int           pending;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off;
    longint       cycle_count;

    segment_circle_hit_test DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    hit_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("segment_circle_hit_test verification failed");
                $finish;
            end
        end
    end

    // Drive ready at random, with a long hold-off when requested
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [111:0] pack_item(logic [15:0] ax, logic [15:0] ay,
        logic [15:0] bx, logic [15:0] by, logic [15:0] cx, logic [15:0] cy,
        logic [14:0] r);
        return {1'b0, r, cy, cx, by, bx, ay, ax};
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(logic [111:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly geometry near the circle, some full-range noise
    function automatic logic [111:0] random_item();
        int span;
        logic signed [15:0] cx, cy;
        logic [14:0] r;
        if ($urandom_range(9) == 0)
            return 112'({$urandom, $urandom, $urandom, $urandom}) & {1'b0, {111{1'b1}}};
        span = (1 << $urandom_range(15, 2)) - 1;
        cx = 16'($urandom);
        cy = 16'($urandom);
        r = 15'($urandom_range(span));
        return pack_item(16'(cx + $signed($urandom_range(2*span) - span)),
                         16'(cy + $signed($urandom_range(2*span) - span)),
                         16'(cx + $signed($urandom_range(2*span) - span)),
                         16'(cy + $signed($urandom_range(2*span) - span)),
                         cx, cy, r);
    endfunction

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 9;
        recv_idle_pct = 60;
        hold_off = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, zero length, inside, tangent, miss, crossing
        send_item(pack_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0, 16'h0, 15'h7fff));
        send_item(pack_item(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 15'h0));
        send_item(pack_item(16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 15'd3));
        send_item(pack_item(16'd1, 16'd1, 16'hffff, 16'hffff, 16'd0, 16'd0, 15'd10));
        send_item(pack_item(16'hfff6, 16'd5, 16'd10, 16'd5, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'hfff6, 16'd6, 16'd10, 16'd6, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'hfff6, 16'd0, 16'd10, 16'd0, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'd0, 16'd0, 16'd20, 16'd0, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'd5, 16'd0, 16'd20, 16'd0, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'd6, 16'd0, 16'd20, 16'd0, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'd20, 16'd0, 16'd6, 16'd0, 16'd0, 16'd0, 15'd5));
        send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0, 15'h7fff));
        send_item({112{1'b1}} >> 1);
        send_item('0);

        for (int i = 0; i < 1900; i++)
        begin
            if (i == 630)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 9;
            end
            if (i == 1260)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == 300 || i == 1500)
                hold_off = 60;
            send_item(random_item());
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("segment_circle_hit_test verification clean");
        else
            $display("segment_circle_hit_test verification failed");
        $finish;
    end

endmodule
